// ----- hdl/tpt_pkg.sv -----
// Shared types and constants of the TLB and page table translation core.
package tpt_pkg;

  localparam int unsigned TLB_SETS         = 8;
  localparam int unsigned TLB_WAYS         = 2;
  localparam int unsigned PAGE_OFFSET_BITS = 11;
  localparam int unsigned PAGE_NUMBER_BITS = 7;
  localparam int unsigned FRAME_BITS       = 7;
  localparam int unsigned VA_BITS          = 32;
  localparam int unsigned LEGAL_BITS       = PAGE_OFFSET_BITS + PAGE_NUMBER_BITS;
  localparam int unsigned SET_BITS         = $clog2(TLB_SETS);
  localparam int unsigned TAG_BITS         = PAGE_NUMBER_BITS - SET_BITS;
  localparam int unsigned WAY_BITS         = (TLB_WAYS > 1) ? $clog2(TLB_WAYS) : 1;
  localparam int unsigned PT_ENTRIES       = 1 << PAGE_NUMBER_BITS;
  localparam int unsigned PA_BITS          = FRAME_BITS + PAGE_OFFSET_BITS;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_TLB_WRITE = 2'd1;
  localparam logic [1:0] CMD_PT_WRITE  = 2'd2;

  typedef enum logic [2:0] {
    ST_TLB_HIT = 3'd0,
    ST_PT_HIT  = 3'd1,
    ST_FAULT   = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_WRITTEN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_TRANSLATE,
    OP_TLB_WRITE,
    OP_PT_WRITE,
    OP_REJECT
  } op_e;

  typedef struct packed {
    logic [1:0]                  command;
    logic [VA_BITS-1:0]          virtual_address;
    logic [PAGE_NUMBER_BITS-1:0] entry_index;
    logic [WAY_BITS-1:0]         entry_way;
    logic                        entry_valid;
    logic [TAG_BITS-1:0]         entry_tag;
    logic [FRAME_BITS-1:0]       entry_frame;
  } req_t;

  typedef struct packed {
    logic [PA_BITS-1:0] physical_address;
    status_e            status;
  } res_t;

  // classified beat: page is the vpn for translations, the entry index for writes
  typedef struct packed {
    op_e                         kind;
    logic [PAGE_NUMBER_BITS-1:0] page;
    logic [TAG_BITS-1:0]         tag;
    logic [PAGE_OFFSET_BITS-1:0] offset;
    logic [WAY_BITS-1:0]         way;
    logic                        valid;
    logic [FRAME_BITS-1:0]       frame;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hdl/tpt_front.sv -----
// Front end: accepts request beats and classifies them into operations.
module tpt_front import tpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  req_t      req_i,
  input  q_status_t q_status_i,
  output logic      busy_o,
  output logic      push_o,
  output op_t       op_o
);

  logic legal;
  logic [PAGE_NUMBER_BITS-1:0] vpn;

  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  assign legal = (req_i.virtual_address[VA_BITS-1:LEGAL_BITS] == '0);
  assign vpn   = req_i.virtual_address[LEGAL_BITS-1:PAGE_OFFSET_BITS];

  always_comb begin
    op_o        = '0;
    op_o.offset = req_i.virtual_address[PAGE_OFFSET_BITS-1:0];
    op_o.way    = req_i.entry_way;
    op_o.valid  = req_i.entry_valid;
    op_o.frame  = req_i.entry_frame;
    op_o.page   = req_i.entry_index;
    op_o.tag    = req_i.entry_tag;
    unique case (req_i.command)
      CMD_TRANSLATE: begin
        op_o.kind = legal ? OP_TRANSLATE : OP_REJECT;
        op_o.page = vpn;
        op_o.tag  = vpn[PAGE_NUMBER_BITS-1:SET_BITS];
      end
      CMD_TLB_WRITE: op_o.kind = OP_TLB_WRITE;
      CMD_PT_WRITE:  op_o.kind = OP_PT_WRITE;
      default:       op_o.kind = OP_REJECT;
    endcase
  end

  // a beat offered while the queue is full must not be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (start_i && !busy_o))
    else $error("push without an accepted beat");

endmodule

// ----- hdl/tpt_queue.sv -----
// Small FIFO that decouples the front end from the back end.
module tpt_queue import tpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  op_t       data_i,
  input  logic      pop_i,
  output op_t       data_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !status_o.full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count did not follow a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i && !status_o.empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("queue count did not follow a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ----- hdl/tpt_back.sv -----
// Back end: TLB lookup, page table RAM and result generation.
module tpt_back import tpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  op_t       head_i,
  output logic      pop_o,
  output logic      done_o,
  output res_t      res_o
);

  typedef struct packed {
    op_e                         kind;
    logic [PAGE_OFFSET_BITS-1:0] offset;
    logic                        tlb_hit;
    logic [FRAME_BITS-1:0]       tlb_frame;
    logic                        pt_valid;
  } stage_t;

  logic                  tlb_valid_q [TLB_SETS][TLB_WAYS];
  logic [TAG_BITS-1:0]   tlb_tag_q   [TLB_SETS][TLB_WAYS];
  logic [FRAME_BITS-1:0] tlb_frame_q [TLB_SETS][TLB_WAYS];
  logic                  pt_valid_q  [PT_ENTRIES];
  logic [FRAME_BITS-1:0] pt_frame_mem [PT_ENTRIES];
  logic [FRAME_BITS-1:0] pt_rdata_q;

  logic                  s1_valid_q;
  stage_t                s1_q, s1_d;
  logic [SET_BITS-1:0]   set;
  logic                  hit;
  logic [FRAME_BITS-1:0] hit_frame;

  assign pop_o = !q_status_i.empty;
  assign set   = head_i.page[SET_BITS-1:0];

  // first matching way wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int w = 0; w < TLB_WAYS; w++) begin
      if (!hit && tlb_valid_q[set][w] && (tlb_tag_q[set][w] == head_i.tag)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_q[set][w];
      end
    end
  end

  always_comb begin
    s1_d.kind      = head_i.kind;
    s1_d.offset    = head_i.offset;
    s1_d.tlb_hit   = hit;
    s1_d.tlb_frame = hit_frame;
    s1_d.pt_valid  = pt_valid_q[head_i.page];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TLB_SETS; s++) begin
        for (int w = 0; w < TLB_WAYS; w++) begin
          tlb_valid_q[s][w] <= 1'b0;
        end
      end
      for (int i = 0; i < PT_ENTRIES; i++) begin
        pt_valid_q[i] <= 1'b0;
      end
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
      if (pop_o && (head_i.kind == OP_TLB_WRITE)) begin
        tlb_valid_q[set][head_i.way] <= head_i.valid;
      end
      if (pop_o && (head_i.kind == OP_PT_WRITE)) begin
        pt_valid_q[head_i.page] <= head_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
    if (pop_o && (head_i.kind == OP_TLB_WRITE)) begin
      tlb_tag_q[set][head_i.way]   <= head_i.tag;
      tlb_frame_q[set][head_i.way] <= head_i.frame;
    end
  end

  // page table RAM, one port
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == OP_PT_WRITE)) begin
      pt_frame_mem[head_i.page] <= head_i.frame;
    end else if (pop_o && (head_i.kind == OP_TRANSLATE)) begin
      pt_rdata_q <= pt_frame_mem[head_i.page];
    end
  end

  assign done_o = s1_valid_q;

  always_comb begin
    res_o = '{physical_address: '0, status: ST_ILLEGAL};
    unique case (s1_q.kind)
      OP_TRANSLATE: begin
        if (s1_q.tlb_hit) begin
          res_o.physical_address = {s1_q.tlb_frame, s1_q.offset};
          res_o.status           = ST_TLB_HIT;
        end else if (s1_q.pt_valid) begin
          res_o.physical_address = {pt_rdata_q, s1_q.offset};
          res_o.status           = ST_PT_HIT;
        end else begin
          res_o.status = ST_FAULT;
        end
      end
      OP_TLB_WRITE, OP_PT_WRITE: res_o.status = ST_WRITTEN;
      default:                   res_o.status = ST_ILLEGAL;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> done_o)
    else $error("popped beat produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.physical_address != '0)) |->
      (res_o.status == ST_TLB_HIT || res_o.status == ST_PT_HIT))
    else $error("nonzero address without a hit");

endmodule

// ----- hdl/tlb_page_table_translate_core.sv -----
// Top level of the TLB and page table translation core.
//
// Request channel: a beat on req_i is taken at a rising edge with start_i high
// and busy_o low. Commands translate an address, write a TLB entry (set and
// way) or write a page table entry.
// Result channel: done_o is high for exactly one cycle per request, with the
// physical address and status on res_o. Results come back in request order.
// The receiver cannot stall; every result must be taken in its cycle.
// A taken request is written into the queue, then its lookup is registered
// in the back end result stage that drives done_o and res_o. Throughput: one
// request per cycle, set by the single page table RAM port, which the back end
// reads or writes once a cycle. A short queue sits between front end and back
// end; busy_o rises only when it fills, which cannot happen while the back end
// drains a beat each cycle. A write is visible to the very next request.
// Reset clears all TLB and page table valid bits, the queue and the result
// strobe at once; tags and frames stay undefined until written.
module tlb_page_table_translate_core import tpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  q_status_t q_status;
  logic      push, pop;
  op_t       push_op, head_op;

  tpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .q_status_i (q_status),
    .busy_o     (busy_o),
    .push_o     (push),
    .op_o       (push_op)
  );

  tpt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_op),
    .pop_i    (pop),
    .data_o   (head_op),
    .status_o (q_status)
  );

  tpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .head_i     (head_op),
    .pop_o      (pop),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ----- sim/tb_tlb_page_table_translate_core.sv -----
// Self-checking testbench for the TLB and page table translation core.
`timescale 1ns / 100ps

module tb_tlb_page_table_translate_core;
  import tpt_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned TLB_ENTRIES = TLB_SETS * TLB_WAYS;
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  logic                  tlb_vld   [TLB_ENTRIES];
  logic [TAG_BITS-1:0]   tlb_tag   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0] tlb_frame [TLB_ENTRIES];
  logic                  pt_vld    [PT_ENTRIES];
  logic [FRAME_BITS-1:0] pt_frame  [PT_ENTRIES];

  res_t        pending_results[$];
  res_t        oldest_result;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  tlb_page_table_translate_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Translation result of one beat; applies its writes to the shadow tables.
  function automatic res_t expected_translation(req_t r);
    res_t                        x;
    logic [PAGE_NUMBER_BITS-1:0] vpn;
    logic [SET_BITS-1:0]         set_idx;
    logic [TAG_BITS-1:0]         tag;
    logic [PAGE_OFFSET_BITS-1:0] offset;
    int unsigned                 e;
    bit                          hit;
    x.physical_address = '0;
    x.status = ST_ILLEGAL;
    hit = 1'b0;
    case (r.command)
      CMD_TRANSLATE: begin
        if ((r.virtual_address >> LEGAL_BITS) == 0) begin
          offset = r.virtual_address[PAGE_OFFSET_BITS-1:0];
          vpn = r.virtual_address[LEGAL_BITS-1:PAGE_OFFSET_BITS];
          set_idx = vpn[SET_BITS-1:0];
          tag = vpn[PAGE_NUMBER_BITS-1:SET_BITS];
          x.status = ST_FAULT;
          for (int w = 0; w < TLB_WAYS; w++) begin
            e = int'(set_idx) * TLB_WAYS + w;
            if (!hit && tlb_vld[e] && tlb_tag[e] == tag) begin
              hit = 1'b1;
              x.physical_address = {tlb_frame[e], offset};
              x.status = ST_TLB_HIT;
            end
          end
          if (!hit && pt_vld[vpn]) begin
            x.physical_address = {pt_frame[vpn], offset};
            x.status = ST_PT_HIT;
          end
        end
      end
      CMD_TLB_WRITE: begin
        e = int'(r.entry_index[SET_BITS-1:0]) * TLB_WAYS + int'(r.entry_way) % TLB_WAYS;
        tlb_vld[e] = r.entry_valid;
        tlb_tag[e] = r.entry_tag;
        tlb_frame[e] = r.entry_frame;
        x.status = ST_WRITTEN;
      end
      CMD_PT_WRITE: begin
        pt_vld[r.entry_index] = r.entry_valid;
        pt_frame[r.entry_index] = r.entry_frame;
        x.status = ST_WRITTEN;
      end
      default: x.status = ST_ILLEGAL;
    endcase
    return x;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, 32'(res_o));
        end else begin
          oldest_result = pending_results.pop_front();
          if (res_o.physical_address !== oldest_result.physical_address)
            report_mismatch("physical_address", 32'(oldest_result.physical_address),
                            32'(res_o.physical_address));
          if (res_o.status !== oldest_result.status)
            report_mismatch("status", 32'(oldest_result.status), 32'(res_o.status));
        end
      end
      if (start_i && !busy_o)
        pending_results.push_back(expected_translation(req_i));
      if (done_o || (start_i && !busy_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  always @(negedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] cmd, logic [VA_BITS-1:0] va,
                                    logic [PAGE_NUMBER_BITS-1:0] idx, logic [WAY_BITS-1:0] way,
                                    logic vld, logic [TAG_BITS-1:0] tag,
                                    logic [FRAME_BITS-1:0] frm);
    req_t r;
    r.command = cmd;
    r.virtual_address = va;
    r.entry_index = idx;
    r.entry_way = way;
    r.entry_valid = vld;
    r.entry_tag = tag;
    r.entry_frame = frm;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t                        r;
    int unsigned                 pick;
    int unsigned                 e;
    logic [PAGE_NUMBER_BITS-1:0] vpn;
    logic [SET_BITS-1:0]         set_idx;
    r.command = CMD_TRANSLATE;
    r.virtual_address = $urandom;
    r.entry_index = PAGE_NUMBER_BITS'($urandom_range(PT_ENTRIES - 1));
    r.entry_way = WAY_BITS'($urandom_range(TLB_WAYS - 1));
    r.entry_valid = $urandom_range(3) != 0;
    r.entry_tag = TAG_BITS'($urandom_range((1 << TAG_BITS) - 1));
    r.entry_frame = FRAME_BITS'($urandom_range((1 << FRAME_BITS) - 1));
    pick = $urandom_range(99);
    if (pick < 18) begin
      r.command = CMD_TLB_WRITE;
    end else if (pick < 32) begin
      r.command = CMD_PT_WRITE;
    end else if (pick < 36) begin
      r.command = CMD_UNKNOWN;
    end else if (pick < 44) begin
      r.virtual_address = $urandom | (32'd1 << $urandom_range(VA_BITS - 1, LEGAL_BITS));
    end else begin
      r.virtual_address[VA_BITS-1:LEGAL_BITS] = '0;
      if ($urandom_range(1) == 0) begin
        // aim at a page whose tag sits in the TLB
        e = $urandom_range(TLB_ENTRIES - 1);
        set_idx = SET_BITS'(e / TLB_WAYS);
        vpn = {tlb_tag[e], set_idx};
        r.virtual_address[LEGAL_BITS-1:PAGE_OFFSET_BITS] = vpn;
      end
    end
    return r;
  endfunction

  task automatic send_beat(req_t r, int unsigned idle_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // No table is read here: only illegal translations and the unused command.
  task automatic test_after_reset();
    send_beat(make_req(CMD_TRANSLATE, 32'h0004_0000, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_UNKNOWN, 32'h0000_0000, '1, '1, 1'b1, '1, '1), 0);
  endtask

  task automatic test_invalid_fill();
    logic [PAGE_NUMBER_BITS-1:0] idx;
    for (int e = 0; e < TLB_ENTRIES; e++) begin
      idx = PAGE_NUMBER_BITS'($urandom_range(PT_ENTRIES - 1));
      idx[SET_BITS-1:0] = SET_BITS'(e / TLB_WAYS);
      send_beat(make_req(CMD_TLB_WRITE, $urandom, idx, WAY_BITS'(e % TLB_WAYS), 1'b0,
                         TAG_BITS'($urandom_range((1 << TAG_BITS) - 1)),
                         FRAME_BITS'($urandom_range((1 << FRAME_BITS) - 1))), 10);
    end
    for (int p = 0; p < PT_ENTRIES; p++)
      send_beat(make_req(CMD_PT_WRITE, $urandom, PAGE_NUMBER_BITS'(p),
                         WAY_BITS'($urandom_range(1)), 1'b0,
                         TAG_BITS'($urandom_range((1 << TAG_BITS) - 1)),
                         FRAME_BITS'($urandom_range((1 << FRAME_BITS) - 1))), 10);
  endtask

  task automatic test_directed();
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_0000, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h7F, 1'b1, 1'b1, 4'hF, 7'h7F), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0003_FFFF, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0004_0000, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'hFFFF_FFFF, '1, '1, 1'b1, '1, '1), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h8000_0000, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_PT_WRITE, 32'h0, 7'h00, 1'b0, 1'b1, 4'h0, 7'h00), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_0005, '0, '0, 1'b0, '0, '0), 0);
    // same tag in both ways: way 0 wins, then way 1 once way 0 drops out
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h08, 1'b0, 1'b1, 4'h0, 7'h55), 0);
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h00, 1'b1, 1'b1, 4'h0, 7'h2A), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_07FF, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h00, 1'b0, 1'b0, 4'h0, 7'h11), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_07FF, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h00, 1'b1, 1'b0, 4'h0, 7'h00), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_07FF, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_PT_WRITE, 32'h0, 7'h7F, 1'b0, 1'b1, 4'h0, 7'h7F), 0);
    send_beat(make_req(CMD_TLB_WRITE, 32'h0, 7'h07, 1'b1, 1'b0, 4'hF, 7'h00), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0003_FFFF, '0, '0, 1'b0, '0, '0), 0);
    send_beat(make_req(CMD_PT_WRITE, 32'h0, 7'h00, 1'b0, 1'b0, 4'h0, 7'h7F), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_0000, '0, '0, 1'b0, '0, '0), 0);
    // unused command must not write the page table
    send_beat(make_req(CMD_UNKNOWN, 32'hFFFF_FFFF, 7'h00, 1'b1, 1'b1, 4'hF, 7'h7F), 0);
    send_beat(make_req(CMD_TRANSLATE, 32'h0000_07FF, '0, '0, 1'b0, '0, '0), 0);
  endtask

  task automatic test_random_traffic(int unsigned beats, int unsigned idle_pct);
    for (int unsigned i = 0; i < beats; i++)
      send_beat(random_request(), idle_pct);
  endtask

  initial begin
    for (int e = 0; e < TLB_ENTRIES; e++)
      tlb_vld[e] = 1'b0;
    for (int p = 0; p < PT_ENTRIES; p++)
      pt_vld[p] = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_after_reset();
    test_invalid_fill();
    test_directed();
    wait_drained();
    test_random_traffic(330, 29);
    wait_drained();
    test_random_traffic(330, 85);
    wait_drained();
    test_random_traffic(330, 0);
    wait_drained();
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
